### src/mbf_pkg.sv
// ----------------------------------------------------------------------------
// mbf_pkg: shared types and constants for the Mandelbrot escape-time engine
// Token layout carried around the iteration ring, outcome codes, defaults.
// ----------------------------------------------------------------------------
package mbf_pkg;

    localparam int FRACTION_BITS_DEF = 25;
    localparam int SNAPSHOT_PERIOD   = 20;
    localparam logic [7:0] LIMIT_RESET = 8'd40;

    // register indexes on the config port
    localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
    localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
    localparam logic [2:0] REG_STEP_RE   = 3'd2;
    localparam logic [2:0] REG_STEP_IM   = 3'd3;
    localparam logic [2:0] REG_LIMIT     = 3'd4;

    typedef enum logic [1:0] {
        OUT_ESCAPED = 2'd0,
        OUT_CYCLE   = 2'd1,
        OUT_LIMIT   = 2'd2
    } outcome_t;

    // one pixel context in flight
    typedef struct packed {
        logic        valid;
        logic        init;     // c not yet formed
        logic        iter;     // new z formed, cycle check pending
        logic        done;
        logic [1:0]  seq;
        outcome_t    outcome;
        logic [7:0]  count;
        logic [4:0]  period;
        logic [9:0]  px;
        logic [9:0]  py;
        logic [31:0] zr;
        logic [31:0] zi;
        logic [31:0] cr;
        logic [31:0] ci;
        logic [31:0] sr;
        logic [31:0] si;
        logic [31:0] m0;       // zr^2 or px*step_re
        logic [31:0] m1;       // zi^2 or py*step_im
        logic [31:0] m2;       // zr*zi
    } tok_t;

endpackage

### src/mbf_mul_stage.sv
// ----------------------------------------------------------------------------
// mbf_mul_stage: multiplier stage of the iteration ring
// Forms zr^2, zi^2, zr*zi (or the pixel offsets on the setup pass).
// ----------------------------------------------------------------------------
module mbf_mul_stage #(
    parameter int FRACTION_BITS = mbf_pkg::FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   step_re,
    input  logic [31:0]   step_im,
    input  mbf_pkg::tok_t tok_in,
    output mbf_pkg::tok_t tok_reg
);

    mbf_pkg::tok_t      tok_next;
    logic [31:0]        op0a;
    logic [31:0]        op0b;
    logic [31:0]        op1a;
    logic [31:0]        op1b;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;

    always_comb
    begin
        op0a = tok_in.init ? {22'd0, tok_in.px} : tok_in.zr;
        op0b = tok_in.init ? step_re : tok_in.zr;
        op1a = tok_in.init ? {22'd0, tok_in.py} : tok_in.zi;
        op1b = tok_in.init ? step_im : tok_in.zi;
        p0   = 64'($signed(op0a)) * 64'($signed(op0b));
        p1   = 64'($signed(op1a)) * 64'($signed(op1b));
        p2   = 64'($signed(tok_in.zr)) * 64'($signed(tok_in.zi));
        tok_next = tok_in;
        if (tok_in.init)
        begin
            // wrapped integer product on the setup pass
            tok_next.m0 = p0[31:0];
            tok_next.m1 = p1[31:0];
        end
        else
        begin
            tok_next.m0 = p0[FRACTION_BITS +: 32];
            tok_next.m1 = p1[FRACTION_BITS +: 32];
        end
        tok_next.m2 = p2[FRACTION_BITS +: 32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

endmodule

### src/mbf_update_stage.sv
// ----------------------------------------------------------------------------
// mbf_update_stage: escape test and z update
// Forms c on the setup pass; otherwise tests limit and |z|^2, then z^2 + c.
// ----------------------------------------------------------------------------
module mbf_update_stage #(
    parameter int FRACTION_BITS = mbf_pkg::FRACTION_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   origin_re,
    input  logic [31:0]   origin_im,
    input  logic [7:0]    limit,
    input  mbf_pkg::tok_t tok_in,
    output mbf_pkg::tok_t tok_reg
);

    localparam logic [31:0] ESCAPE_BOUND = 32'(4) << FRACTION_BITS;

    mbf_pkg::tok_t tok_next;
    logic [31:0]   cr_new;
    logic [31:0]   ci_new;
    logic [31:0]   mag;

    always_comb
    begin
        cr_new   = origin_re + tok_in.m0;
        ci_new   = origin_im + tok_in.m1;
        mag      = tok_in.m0 + tok_in.m1;
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.done)
        begin
            if (tok_in.init)
            begin
                tok_next.init   = 1'b0;
                tok_next.cr     = cr_new;
                tok_next.ci     = ci_new;
                tok_next.zr     = cr_new;
                tok_next.zi     = ci_new;
                tok_next.sr     = cr_new;
                tok_next.si     = ci_new;
                tok_next.count  = '0;
                tok_next.period = '0;
            end
            else if (tok_in.count >= limit)
            begin
                tok_next.done    = 1'b1;
                tok_next.outcome = mbf_pkg::OUT_LIMIT;
                tok_next.count   = limit;
            end
            else if ($signed(mag) >= $signed(ESCAPE_BOUND))
            begin
                tok_next.done    = 1'b1;
                tok_next.outcome = mbf_pkg::OUT_ESCAPED;
            end
            else
            begin
                tok_next.zr   = tok_in.m0 - tok_in.m1 + tok_in.cr;
                tok_next.zi   = {tok_in.m2[30:0], 1'b0} + tok_in.ci;
                tok_next.iter = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

endmodule

### src/mbf_check_stage.sv
// ----------------------------------------------------------------------------
// mbf_check_stage: cycle detection and snapshot refresh
// Compares new z with the snapshot, advances the iteration index.
// ----------------------------------------------------------------------------
module mbf_check_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  mbf_pkg::tok_t tok_in,
    output mbf_pkg::tok_t tok_reg
);

    mbf_pkg::tok_t tok_next;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && tok_in.iter)
        begin
            tok_next.iter = 1'b0;
            if (tok_in.zr == tok_in.sr && tok_in.zi == tok_in.si)
            begin
                tok_next.done    = 1'b1;
                tok_next.outcome = mbf_pkg::OUT_CYCLE;
            end
            else
            begin
                tok_next.count = tok_in.count + 8'd1;
                if (tok_in.period == 5'(mbf_pkg::SNAPSHOT_PERIOD))
                begin
                    tok_next.period = '0;
                    tok_next.sr     = tok_in.zr;
                    tok_next.si     = tok_in.zi;
                end
                else
                    tok_next.period = tok_in.period + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

endmodule

### src/mandelbrot_escape_time_fixed.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_fixed: fixed-point Mandelbrot escape-time engine
// Three-stage iteration ring shared by up to three pixels, in-order results.
// ----------------------------------------------------------------------------
// Flow: a setup pass around the ring forms c, then each further pass runs one
//   iteration; a finished token waits in the ring until it is the oldest and
//   the output register is free, then loads that register and raises out_valid.
// Throughput: the 3-stage multiply/update/check ring holds up to three pixels;
//   with three pixels still iterating it runs one iteration per cycle overall.
// Reset: ring and output emptied, origin/step cleared, iteration limit 40.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_fixed #(
    parameter int FRACTION_BITS = mbf_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // pixel input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  pixel_x,
    input  logic [9:0]  pixel_y,
    // result output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  outcome,
    output logic [7:0]  iteration_count,
    output logic [9:0]  out_x,
    output logic [9:0]  out_y
);

    // config registers
    logic [31:0] origin_re_reg;
    logic [31:0] origin_im_reg;
    logic [31:0] step_re_reg;
    logic [31:0] step_im_reg;
    logic [7:0]  limit_reg;

    // ring stages: a = products, b = update, c = check
    mbf_pkg::tok_t ring_in;
    mbf_pkg::tok_t a_reg;
    mbf_pkg::tok_t b_reg;
    mbf_pkg::tok_t c_reg;
    mbf_pkg::tok_t new_tok;

    // sequence tags keep results in arrival order
    logic [1:0] head_reg;
    logic [1:0] tail_reg;

    logic       out_valid_reg;
    logic [1:0] outcome_reg;
    logic [7:0] count_reg;
    logic [9:0] x_reg;
    logic [9:0] y_reg;

    logic out_free;
    logic leave;
    logic slot_free;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= '0;
            origin_im_reg <= '0;
            step_re_reg   <= '0;
            step_im_reg   <= '0;
            limit_reg     <= mbf_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbf_pkg::REG_ORIGIN_RE: origin_re_reg <= cfg_data;
                mbf_pkg::REG_ORIGIN_IM: origin_im_reg <= cfg_data;
                mbf_pkg::REG_STEP_RE:   step_re_reg   <= cfg_data;
                mbf_pkg::REG_STEP_IM:   step_im_reg   <= cfg_data;
                mbf_pkg::REG_LIMIT:     limit_reg     <= cfg_data[7:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // a finished token leaves only when it is the oldest and the output frees
    assign out_free  = !out_valid_reg || !out_stall;
    assign leave     = c_reg.valid && c_reg.done && (c_reg.seq == head_reg) && out_free;
    assign slot_free = !c_reg.valid || leave;
    assign accept    = in_valid && slot_free;
    assign in_stall  = !slot_free;

    always_comb
    begin
        new_tok       = '0;
        new_tok.valid = 1'b1;
        new_tok.init  = 1'b1;
        new_tok.seq   = tail_reg;
        new_tok.px    = pixel_x;
        new_tok.py    = pixel_y;
        if (accept)
            ring_in = new_tok;
        else if (leave)
            ring_in = '0;
        else
            ring_in = c_reg;  // running or parked tokens go around again
    end

    mbf_mul_stage #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_re (step_re_reg),
        .step_im (step_im_reg),
        .tok_in  (ring_in),
        .tok_reg (a_reg)
    );

    mbf_update_stage #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .origin_re (origin_re_reg),
        .origin_im (origin_im_reg),
        .limit     (limit_reg),
        .tok_in    (a_reg),
        .tok_reg   (b_reg)
    );

    mbf_check_stage u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (b_reg),
        .tok_reg (c_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                tail_reg <= tail_reg + 2'd1;
            if (leave)
                head_reg <= head_reg + 2'd1;
            if (leave)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded on each transfer out of the ring
    always_ff @(posedge clk)
    begin
        if (leave)
        begin
            outcome_reg <= c_reg.outcome;
            count_reg   <= c_reg.count;
            x_reg       <= c_reg.px;
            y_reg       <= c_reg.py;
        end
    end

    assign out_valid       = out_valid_reg;
    assign outcome         = outcome_reg;
    assign iteration_count = count_reg;
    assign out_x           = x_reg;
    assign out_y           = y_reg;

endmodule
